// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int DEPTH = MAX_X * MAX_Y;
  localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SXW   = ($clog2(MAX_X + 1) > 7) ? $clog2(MAX_X + 1) : 7;
  localparam int SYW   = ($clog2(MAX_Y + 1) > 7) ? $clog2(MAX_Y + 1) : 7;
  localparam int ZW    = 11;
  localparam int NPORT = 5;

  typedef enum logic [1:0] {
    PH_LOWER = 2'd0,
    PH_GRID  = 2'd1,
    PH_UPPER = 2'd2
  } ple_phase_e;

  typedef enum logic [2:0] {
    REG_SIZE_X     = 3'd0,
    REG_SIZE_Y     = 3'd1,
    REG_SIZE_Z     = 3'd2,
    REG_DIFF_GAIN  = 3'd3,
    REG_FORCE_GAIN = 3'd4
  } ple_reg_e;

  // read ports: centre, x-1, x+1, y-1, y+1
  typedef struct packed {
    logic                        valid;
    logic                        bank;
    logic                        last;
    logic                        we_a;
    logic                        we_b;
    logic                        we_f;
    logic [NPORT-1:0][AW-1:0]    addr;
  } ple_cmd_t;

endpackage

// ===== rtl/core/ple_ram.sv =====
module ple_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

// ===== rtl/core/ple_ctrl.sv =====
module ple_ctrl import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  output ple_cmd_t    cmd_o,
  output logic [31:0] diff_gain_o,
  output logic [31:0] force_gain_o
);

  logic [6:0]  size_x_q, size_y_q;
  logic [10:0] size_z_q;
  logic [31:0] diff_gain_q, force_gain_q;

  ple_phase_e  phase_q, phase_d;
  logic [XW-1:0] pos_x_q, pos_x_d;
  logic [YW-1:0] pos_y_q, pos_y_d;
  logic [ZW-1:0] pos_z_q, pos_z_d;
  logic          bank_q, bank_d;

  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [ZW-1:0]  sz;
  logic           x_last, y_last, hit, z_first, restart;
  logic [XW-1:0]  xm, xp;
  logic [YW-1:0]  ym, yp;
  logic           tgt_pv, tgt_cv;

  assign restart = cfg_valid_i && (cfg_index_i == REG_SIZE_X || cfg_index_i == REG_SIZE_Y ||
                                   cfg_index_i == REG_SIZE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= 7'd64;
      size_y_q     <= 7'd64;
      size_z_q     <= 11'd1;
      diff_gain_q  <= '0;
      force_gain_q <= 32'd16777216;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIZE_X:     size_x_q     <= cfg_data_i[6:0];
        REG_SIZE_Y:     size_y_q     <= cfg_data_i[6:0];
        REG_SIZE_Z:     size_z_q     <= cfg_data_i[10:0];
        REG_DIFF_GAIN:  diff_gain_q  <= cfg_data_i;
        REG_FORCE_GAIN: force_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign diff_gain_o  = diff_gain_q;
  assign force_gain_o = force_gain_q;

  always_comb begin
    if (size_x_q == '0) begin
      sx = SXW'(1);
    end else if (SXW'(size_x_q) > SXW'(MAX_X)) begin
      sx = SXW'(MAX_X);
    end else begin
      sx = SXW'(size_x_q);
    end
    if (size_y_q == '0) begin
      sy = SYW'(1);
    end else if (SYW'(size_y_q) > SYW'(MAX_Y)) begin
      sy = SYW'(MAX_Y);
    end else begin
      sy = SYW'(size_y_q);
    end
    sz = (size_z_q == '0) ? ZW'(1) : size_z_q;
  end

  assign x_last  = (SXW'(pos_x_q) == sx - SXW'(1));
  assign y_last  = (SYW'(pos_y_q) == sy - SYW'(1));
  assign xm      = (pos_x_q == '0) ? XW'(sx - SXW'(1)) : pos_x_q - XW'(1);
  assign xp      = x_last ? '0 : pos_x_q + XW'(1);
  assign ym      = (pos_y_q == '0) ? YW'(sy - SYW'(1)) : pos_y_q - YW'(1);
  assign yp      = y_last ? '0 : pos_y_q + YW'(1);
  assign z_first = (pos_z_q == '0);
  assign hit     = in_valid_i && in_ready_i && (action_i == phase_q);

  assign tgt_pv = (phase_q == PH_LOWER) || (phase_q == PH_GRID && !z_first);
  assign tgt_cv = (phase_q == PH_GRID) && z_first;

  always_comb begin
    cmd_o.valid   = hit && ((phase_q == PH_UPPER) || (phase_q == PH_GRID && !z_first));
    cmd_o.bank    = bank_q;
    cmd_o.last    = (phase_q == PH_UPPER) && x_last && y_last;
    cmd_o.we_a    = hit && ((tgt_pv && !bank_q) || (tgt_cv && bank_q));
    cmd_o.we_b    = hit && ((tgt_pv && bank_q) || (tgt_cv && !bank_q));
    cmd_o.we_f    = hit && (phase_q == PH_GRID);
    cmd_o.addr[0] = AW'(int'(pos_y_q) * MAX_X + int'(pos_x_q));
    cmd_o.addr[1] = AW'(int'(pos_y_q) * MAX_X + int'(xm));
    cmd_o.addr[2] = AW'(int'(pos_y_q) * MAX_X + int'(xp));
    cmd_o.addr[3] = AW'(int'(ym) * MAX_X + int'(pos_x_q));
    cmd_o.addr[4] = AW'(int'(yp) * MAX_X + int'(pos_x_q));
  end

  always_comb begin
    phase_d = phase_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    bank_d  = bank_q;
    if (restart) begin
      phase_d = PH_LOWER;
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
      bank_d  = 1'b0;
    end else if (hit) begin
      pos_x_d = xp;
      if (x_last) begin
        pos_y_d = yp;
        if (y_last) begin
          case (phase_q)
            PH_LOWER: begin
              phase_d = PH_GRID;
              pos_z_d = '0;
            end
            PH_GRID: begin
              if (!z_first) begin
                bank_d = ~bank_q;
              end
              pos_z_d = pos_z_q + ZW'(1);
              if (pos_z_q + ZW'(1) >= sz) begin
                phase_d = PH_UPPER;
              end
            end
            default: begin
              phase_d = PH_LOWER;
              pos_z_d = '0;
              bank_d  = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LOWER;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      bank_q  <= bank_d;
    end
  end

endmodule

// ===== rtl/core/ple_math.sv =====
module ple_math import ple_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ple_cmd_t                cmd_i,
  input  logic [31:0]             u_i,
  input  logic [NPORT-1:0][31:0]  a_rd_i,
  input  logic [NPORT-1:0][31:0]  b_rd_i,
  input  logic [31:0]             f_rd_i,
  input  logic [31:0]             diff_gain_i,
  input  logic [31:0]             force_gain_i,
  output logic                    load_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [31:0]             new_value_o,
  output logic                    last_o
);

  // s1: read data, s2: laplacian, s3: partial products, then output register
  logic        s1_v_q, s1_bank_q, s1_last_q;
  logic [31:0] s1_u_q;
  logic        s2_v_q, s2_last_q;
  logic signed [35:0] s2_lap_q;
  logic [31:0] s2_c_q, s2_f_q;
  logic        s3_v_q, s3_last_q, s3_sl_q, s3_sf_q;
  logic [31:0] s3_c_q;
  logic [50:0] s3_phl_q, s3_pll_q;
  logic [47:0] s3_phf_q, s3_plf_q;
  logic        o_v_q, o_last_q;
  logic [31:0] o_val_q;

  logic        o_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic [NPORT-1:0][31:0] cv;
  logic [31:0] pv;
  logic signed [35:0] lap, c6;
  logic [34:0] mag_l;
  logic [31:0] mag_f;
  logic [51:0] sum_l;
  logic [48:0] sum_f;
  logic [43:0] q_l;
  logic [40:0] q_f;
  logic signed [45:0] r;
  logic [31:0] sat;

  assign o_rdy  = !o_v_q || out_ready_i;
  assign s3_rdy = !s3_v_q || o_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign load_o = s1_rdy;

  assign cv = s1_bank_q ? a_rd_i : b_rd_i;
  assign pv = s1_bank_q ? b_rd_i[0] : a_rd_i[0];
  assign c6 = (36'(signed'(cv[0])) <<< 2) + (36'(signed'(cv[0])) <<< 1);
  assign lap = 36'(signed'(cv[1])) + 36'(signed'(cv[2])) + 36'(signed'(cv[3]))
             + 36'(signed'(cv[4])) + 36'(signed'(pv)) + 36'(signed'(s1_u_q)) - c6;

  assign mag_l = s2_lap_q[35] ? 35'(-s2_lap_q) : s2_lap_q[34:0];
  assign mag_f = s2_f_q[31] ? 32'(-s2_f_q) : s2_f_q;

  assign sum_l = 52'(s3_phl_q) + 52'((52'(s3_pll_q) + 52'(1 << 23)) >> 16);
  assign sum_f = 49'(s3_phf_q) + 49'((49'(s3_plf_q) + 49'(1 << 23)) >> 16);
  assign q_l   = sum_l[51:8];
  assign q_f   = sum_f[48:8];

  always_comb begin
    r = 46'(signed'(s3_c_q))
      + (s3_sl_q ? -signed'(46'(q_l)) : signed'(46'(q_l)))
      + (s3_sf_q ? -signed'(46'(q_f)) : signed'(46'(q_f)));
    if (r > 46'sd2147483647) begin
      sat = 32'h7fff_ffff;
    end else if (r < -46'sd2147483648) begin
      sat = 32'h8000_0000;
    end else begin
      sat = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= cmd_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (o_rdy)  o_v_q  <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_bank_q <= cmd_i.bank;
      s1_last_q <= cmd_i.last;
      s1_u_q    <= u_i;
    end
    if (s2_rdy) begin
      s2_lap_q  <= lap;
      s2_c_q    <= cv[0];
      s2_f_q    <= f_rd_i;
      s2_last_q <= s1_last_q;
    end
    if (s3_rdy) begin
      s3_phl_q  <= 51'(mag_l * diff_gain_i[31:16]);
      s3_pll_q  <= 51'(mag_l * diff_gain_i[15:0]);
      s3_phf_q  <= 48'(mag_f * force_gain_i[31:16]);
      s3_plf_q  <= 48'(mag_f * force_gain_i[15:0]);
      s3_sl_q   <= s2_lap_q[35];
      s3_sf_q   <= s2_f_q[31];
      s3_c_q    <= s2_c_q;
      s3_last_q <= s2_last_q;
    end
    if (o_rdy) begin
      o_val_q  <= sat;
      o_last_q <= s3_last_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign new_value_o = o_val_q;
  assign last_o      = o_last_q;

endmodule

// ===== rtl/core/periodic_laplacian_explicit_step.sv =====
// Seven-point Laplacian diffusion step over a streamed 3D grid, one velocity
// component per pass.
// Input channel (in_valid_i/in_ready_o): a lower halo plane, size_z grid
// planes with force, then an upper halo plane, all in raster order (x
// fastest). Items whose action does not match the current phase are taken
// and dropped.
// Output channel (out_valid_o/out_ready_i): one result per item from the
// second grid plane on, for the point one plane back; last_o marks the final
// grid point of the frame.
// Config channel (cfg_valid_i/cfg_ready_o): always ready; a size write
// restarts the frame, gain writes apply at once. Write only while idle.
// Throughput is one item per cycle while out_ready_i does not stall the
// pipeline. On the way from input transfer to result on out_*, the plane
// stores are read at the transfer edge, then the stencil sum, the gain
// multipliers, and rounding with saturation are each registered in turn.
// Each velocity plane is held in three copies of a dual-read RAM to serve
// the five stencil reads per cycle.
// Reset returns registers to defaults and the frame to the lower halo phase;
// plane contents are not cleared. A stalled receiver holds the result in the
// output register and backs the pipeline up to in_ready_o.
module periodic_laplacian_explicit_step import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] u_value_i,
  input  logic [31:0] force_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_value_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ple_cmd_t                cmd;
  logic                    load;
  logic [31:0]             diff_gain, force_gain, f_rd;
  logic [NPORT-1:0][31:0]  a_rd, b_rd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = load;

  ple_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (load),
    .action_i     (action_i),
    .cmd_o        (cmd),
    .diff_gain_o  (diff_gain),
    .force_gain_o (force_gain)
  );

  for (genvar k = 0; k < 2; k++) begin : g_pair
    ple_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_ram_a (
      .clk_i    (clk_i),
      .we_i     (cmd.we_a),
      .waddr_i  (cmd.addr[0]),
      .wdata_i  (u_value_i),
      .re_i     (load),
      .raddr0_i (cmd.addr[2*k]),
      .raddr1_i (cmd.addr[2*k+1]),
      .rdata0_o (a_rd[2*k]),
      .rdata1_o (a_rd[2*k+1])
    );
    ple_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_ram_b (
      .clk_i    (clk_i),
      .we_i     (cmd.we_b),
      .waddr_i  (cmd.addr[0]),
      .wdata_i  (u_value_i),
      .re_i     (load),
      .raddr0_i (cmd.addr[2*k]),
      .raddr1_i (cmd.addr[2*k+1]),
      .rdata0_o (b_rd[2*k]),
      .rdata1_o (b_rd[2*k+1])
    );
  end

  ple_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_ram_a4 (
    .clk_i    (clk_i),
    .we_i     (cmd.we_a),
    .waddr_i  (cmd.addr[0]),
    .wdata_i  (u_value_i),
    .re_i     (load),
    .raddr0_i (cmd.addr[4]),
    .raddr1_i (cmd.addr[0]),
    .rdata0_o (a_rd[4]),
    .rdata1_o ()
  );

  ple_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_ram_b4 (
    .clk_i    (clk_i),
    .we_i     (cmd.we_b),
    .waddr_i  (cmd.addr[0]),
    .wdata_i  (u_value_i),
    .re_i     (load),
    .raddr0_i (cmd.addr[4]),
    .raddr1_i (cmd.addr[0]),
    .rdata0_o (b_rd[4]),
    .rdata1_o ()
  );

  ple_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_ram_f (
    .clk_i    (clk_i),
    .we_i     (cmd.we_f),
    .waddr_i  (cmd.addr[0]),
    .wdata_i  (force_value_i),
    .re_i     (load),
    .raddr0_i (cmd.addr[0]),
    .raddr1_i (cmd.addr[0]),
    .rdata0_o (f_rd),
    .rdata1_o ()
  );

  ple_math u_math (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .u_i          (u_value_i),
    .a_rd_i       (a_rd),
    .b_rd_i       (b_rd),
    .f_rd_i       (f_rd),
    .diff_gain_i  (diff_gain),
    .force_gain_i (force_gain),
    .load_o       (load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .new_value_o  (new_value_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/core/ple_chk.sv =====
module ple_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] new_value_o,
  input logic        last_o,
  input logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(new_value_o) && $stable(last_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind periodic_laplacian_explicit_step ple_chk u_ple_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .new_value_o (new_value_o),
  .last_o      (last_o),
  .cfg_ready_o (cfg_ready_o)
);
